FILE: sv/rrts_pkg.sv
// ----------------------------------------------------------------------------
// rrts_pkg
// Types and constants shared by the thermistor sampler modules.
// ----------------------------------------------------------------------------
package rrts_pkg;

  // Converter code width; the request sample field is exactly this wide.
  localparam int unsigned SampleBits = 10;
  localparam int unsigned CfgIdxBits = 1;
  localparam int unsigned CfgDataBits = 20;

  localparam logic [15:0] IntervalReset = 16'd2000;
  localparam logic [19:0] RefOhmsReset  = 20'd10000;

  localparam logic [0:0] CfgInterval = 1'b0;
  localparam logic [0:0] CfgRefOhms  = 1'b1;

  localparam logic OpTick   = 1'b0;
  localparam logic OpSample = 1'b1;

  localparam logic [1:0] KindIndicator = 2'd0;
  localparam logic [1:0] KindRequest   = 2'd1;
  localparam logic [1:0] KindTransmit  = 2'd2;

  // Q40 coefficients, Q30 ln2 and the Q16 offset.
  localparam logic [31:0] C1Q40    = 32'((64'd1129148 << 40) / 64'd1000000000);
  localparam logic [27:0] C2Q40    = 28'((64'd234125 << 40) / 64'd1000000000);
  localparam logic [23:0] C3Q40    = 24'((64'd876741 << 40) / 64'd10000000000000);
  localparam logic [29:0] Ln2Q30   = 30'd744261118;
  localparam logic [24:0] OffsetQ16 = 25'd19211878;

  typedef struct packed {
    logic                  opcode;
    logic [SampleBits-1:0] sample;
  } in_item_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       indicator_on;
    logic [1:0] request_channel;
    logic [7:0] tx_byte;
    logic       last;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic                  start;
    logic [SampleBits-1:0] sample;
  } rrts_cmd_t;

  typedef struct packed {
    logic       busy;
    logic       done;
    logic [7:0] temp;
  } rrts_sts_t;

endpackage

FILE: sv/rrts_datapath.sv
// ----------------------------------------------------------------------------
// rrts_datapath
// Steinhart-Hart temperature byte: log2 by iterated squaring, multiply
// chain and a restoring divider, all on one sequenced set of registers.
// ----------------------------------------------------------------------------
module rrts_datapath (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [19:0]        ref_ohms_i,
  input  rrts_pkg::rrts_cmd_t cmd_i,
  output rrts_pkg::rrts_sts_t sts_o
);
  import rrts_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_NUM, S_NORM, S_SQ, S_LN, S_A2, S_A3, S_T2, S_T3, S_DEN,
    S_DIV, S_OUT
  } dp_state_e;

  localparam logic [SampleBits-1:0] FullScale = {SampleBits{1'b1}};

  dp_state_e   state_q;
  logic [31:0] x_q;        // value whose log is taken
  logic        second_q;   // 0: numerator, 1: denominator
  logic [4:0]  e_q;
  logic [31:0] y_q;        // Q30 mantissa, below 2^31
  logic [15:0] frac_q;
  logic [4:0]  it_q;
  logic [20:0] lnum_q;
  logic [20:0] d_q;
  logic        neg_q;
  logic [35:0] a_q;
  logic [35:0] a2_q;
  logic [35:0] a3_q;
  logic [63:0] t2_q;
  logic [63:0] t3_q;
  logic [57:0] rem_q;
  logic [57:0] den_q;
  logic [56:0] quo_q;
  logic [5:0]  div_q;
  logic [7:0]  temp_q;
  logic        done_q;
  logic        zero_q;

  logic [61:0] sq;
  logic [4:0]  msb;
  logic [20:0] lcur;
  logic [63:0] num_full;
  logic [58:0] trial;
  logic [56:0] deg_kq;

  always_comb begin
    msb = '0;
    for (int i = 0; i < 32; i++) begin
      if (x_q[i]) msb = 5'(i);
    end
  end

  assign sq       = 62'(({32'd0, y_q} * {32'd0, y_q}) >> 30);
  assign lcur     = {e_q, frac_q};
  assign num_full = 64'(ref_ohms_i) * 64'(FullScale - cmd_i.sample[SampleBits-1:0]);
  assign trial    = {rem_q, quo_q[56]} - {1'b0, den_q};
  assign deg_kq   = quo_q - 57'(OffsetQ16);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (cmd_i.start) begin
            second_q <= 1'b0;
            x_q      <= num_full[31:0];
            zero_q   <= 1'b0;
            if (cmd_i.sample[SampleBits-1:0] == '0 ||
                cmd_i.sample[SampleBits-1:0] == FullScale ||
                num_full == 64'd0 || num_full[63:32] != 32'd0) begin
              zero_q  <= 1'b1;
              state_q <= S_OUT;
            end else begin
              state_q <= S_NUM;
            end
          end
        end
        S_NUM: begin
          e_q     <= msb;
          y_q     <= (msb <= 5'd30) ? (x_q << (5'd30 - msb)) : (x_q >> 1);
          frac_q  <= '0;
          it_q    <= 5'd15;
          state_q <= S_SQ;
        end
        S_SQ: begin
          if (sq[61:31] != '0) begin
            y_q <= 32'(sq >> 1);
            frac_q[it_q[3:0]] <= 1'b1;
          end else begin
            y_q <= sq[31:0];
          end
          if (it_q == 5'd0) state_q <= S_NORM;
          else it_q <= it_q - 5'd1;
        end
        S_NORM: begin
          if (!second_q) begin
            lnum_q   <= lcur;
            second_q <= 1'b1;
            x_q      <= 32'(cmd_i.sample[SampleBits-1:0]);
            state_q  <= S_NUM;
          end else begin
            neg_q   <= lcur > lnum_q;
            d_q     <= (lcur > lnum_q) ? lcur - lnum_q : lnum_q - lcur;
            state_q <= S_LN;
          end
        end
        S_LN: begin
          a_q     <= 36'((51'(d_q) * 51'(Ln2Q30)) >> 30);
          state_q <= S_A2;
        end
        S_A2: begin
          a2_q    <= 36'((42'(a_q[20:0]) * 42'(a_q[20:0])) >> 16);
          state_q <= S_A3;
        end
        S_A3: begin
          a3_q    <= 36'((47'(a2_q[25:0]) * 47'(a_q[20:0])) >> 16);
          state_q <= S_T2;
        end
        S_T2: begin
          t2_q    <= (64'(C2Q40) * 64'(a_q[20:0])) >> 16;
          state_q <= S_T3;
        end
        S_T3: begin
          t3_q    <= (64'(C3Q40) * 64'(a3_q[30:0])) >> 16;
          state_q <= S_DEN;
        end
        S_DEN: begin
          rem_q  <= '0;
          quo_q  <= 57'd1 << 56;
          div_q  <= 6'd57;
          if (neg_q) begin
            if (64'(C1Q40) <= t2_q + t3_q) begin
              zero_q  <= 1'b1;
              state_q <= S_OUT;
            end else begin
              den_q   <= 58'(64'(C1Q40) - t2_q - t3_q);
              state_q <= S_DIV;
            end
          end else begin
            den_q   <= 58'(64'(C1Q40) + t2_q + t3_q);
            state_q <= S_DIV;
          end
        end
        S_DIV: begin
          // One quotient bit per cycle, dividend shifted in from quo_q.
          if (!trial[58]) begin
            rem_q <= trial[57:0];
            quo_q <= {quo_q[55:0], 1'b1};
          end else begin
            rem_q <= {rem_q[56:0], quo_q[56]};
            quo_q <= {quo_q[55:0], 1'b0};
          end
          div_q <= div_q - 6'd1;
          if (div_q == 6'd1) state_q <= S_OUT;
        end
        S_OUT: begin
          if (zero_q || quo_q <= 57'(OffsetQ16)) temp_q <= 8'd0;
          else if (deg_kq[56:24] != '0) temp_q <= 8'd255;
          else temp_q <= deg_kq[23:16];
          done_q  <= 1'b1;
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign sts_o.busy = (state_q != S_IDLE);
  assign sts_o.done = done_q;
  assign sts_o.temp = temp_q;

`ifndef SYNTHESIS
  a_done_from_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(state_q) == S_OUT) else $error("done without finish");
  a_no_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SQ) |=> (state_q == S_SQ || state_q == S_NORM))
    else $error("log loop left early");
  a_div_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) |-> div_q != 6'd0) else $error("divider overrun");
`endif
endmodule

FILE: sv/rrts_ctrl.sv
// ----------------------------------------------------------------------------
// rrts_ctrl
// Tick counting, indicator, channel rotation and result sequencing.
// ----------------------------------------------------------------------------
module rrts_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [15:0]         interval_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  rrts_pkg::in_item_t  in_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output rrts_pkg::out_item_t out_o,
  output rrts_pkg::rrts_cmd_t cmd_o,
  input  rrts_pkg::rrts_sts_t sts_i
);
  import rrts_pkg::*;

  typedef enum logic [2:0] {
    C_IDLE, C_EMIT1, C_EMIT2, C_CALC, C_WAIT
  } ctrl_state_e;

  ctrl_state_e state_q;
  logic [15:0] tick_q;
  logic        led_q;
  logic [1:0]  chan_q;
  logic        pend_q;
  logic        ovalid_q;
  out_item_t   out_q;
  out_item_t   second_q;
  logic [SampleBits-1:0] sample_q;
  logic        start_q;

  logic [16:0] cnt;
  logic [15:0] capped;
  logic        accept;

  assign accept     = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == C_IDLE) && !ovalid_q;
  assign cnt        = 17'(tick_q) + 17'd1;
  assign capped     = (cnt > 17'(interval_i)) ? interval_i : cnt[15:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= C_IDLE;
      tick_q   <= '0;
      led_q    <= 1'b0;
      chan_q   <= 2'd2;
      pend_q   <= 1'b0;
      ovalid_q <= 1'b0;
      start_q  <= 1'b0;
    end else begin
      start_q <= 1'b0;
      if (ovalid_q && out_ready_i) ovalid_q <= 1'b0;
      unique case (state_q)
        C_IDLE: begin
          if (accept) begin
            if (in_i.opcode == OpTick) begin
              if (!pend_q && capped >= interval_i) begin
                tick_q   <= '0;
                led_q    <= !led_q;
                ovalid_q <= 1'b1;
                out_q    <= '{KindIndicator, !led_q, 2'd0, 8'd0, led_q};
                if (!led_q) begin
                  pend_q   <= 1'b1;
                  second_q <= '{KindRequest, 1'b1, chan_q, 8'd0, 1'b1};
                  state_q  <= C_EMIT2;
                end
              end else begin
                tick_q <= capped;
              end
            end else if (pend_q) begin
              ovalid_q <= 1'b1;
              out_q    <= '{KindTransmit, led_q, 2'd0, {6'd0, chan_q}, 1'b0};
              sample_q <= in_i.sample;
              pend_q   <= 1'b0;
              if (chan_q == 2'd1) begin
                start_q <= 1'b1;
                state_q <= C_CALC;
              end else begin
                second_q <= '{KindTransmit, led_q, 2'd0,
                              8'(in_i.sample[SampleBits-1:0]), 1'b1};
                state_q  <= C_EMIT2;
              end
              chan_q <= (chan_q == 2'd1) ? 2'd2 : (chan_q == 2'd2) ? 2'd3 : 2'd1;
            end
          end
        end
        C_CALC: begin
          state_q <= C_WAIT;
        end
        C_WAIT: begin
          if (sts_i.done) begin
            second_q <= '{KindTransmit, led_q, 2'd0, sts_i.temp, 1'b1};
            state_q  <= C_EMIT2;
          end
        end
        C_EMIT2: begin
          if (!ovalid_q || out_ready_i) begin
            ovalid_q <= 1'b1;
            out_q    <= second_q;
            state_q  <= C_EMIT1;
          end
        end
        C_EMIT1: begin
          state_q <= C_IDLE;
        end
        default: state_q <= C_IDLE;
      endcase
    end
  end

  assign out_valid_o = ovalid_q;
  assign out_o       = out_q;
  assign cmd_o.start  = start_q;
  assign cmd_o.sample = sample_q;

`ifndef SYNTHESIS
  // A lowered interval may leave the count above it until the next tick.
  a_tick_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_i.opcode == OpTick) |=> tick_q <= $past(interval_i))
    else $error("tick count above interval");
  a_calc_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_q |=> sts_i.busy) else $error("datapath did not start");
  a_no_accept_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> !ovalid_q) else $error("accepted while result held");
`endif
endmodule

FILE: sv/round_robin_thermistor_sampler_unit.sv
// ----------------------------------------------------------------------------
// round_robin_thermistor_sampler_unit
// Tick-driven indicator with round-robin thermistor conversion requests.
// ----------------------------------------------------------------------------
// Channel 1 gives its second byte after the sample once the 16-round log
// loop has run twice, then the multiply chain and the 57-step bit-serial
// divider.
// One item is in flight at a time.
// Reset is asynchronous, active low, and takes effect at once.
module round_robin_thermistor_sampler_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [rrts_pkg::CfgIdxBits-1:0]  cfg_idx_i,
  input  logic [rrts_pkg::CfgDataBits-1:0] cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  rrts_pkg::in_item_t  in_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output rrts_pkg::out_item_t out_o
);
  import rrts_pkg::*;

  logic [15:0] interval_q;
  logic [19:0] ref_q;
  rrts_cmd_t   cmd;
  rrts_sts_t   sts;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      interval_q <= IntervalReset;
      ref_q      <= RefOhmsReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgInterval: interval_q <= cfg_data_i[15:0];
        CfgRefOhms:  ref_q      <= cfg_data_i;
        default: ;
      endcase
    end
  end

  rrts_ctrl u_ctrl (
    .clk_i, .rst_ni, .interval_i(interval_q),
    .in_valid_i, .in_ready_o, .in_i,
    .out_valid_o, .out_ready_i, .out_o,
    .cmd_o(cmd), .sts_i(sts)
  );

  rrts_datapath u_dp (
    .clk_i, .rst_ni, .ref_ohms_i(ref_q), .cmd_i(cmd), .sts_o(sts)
  );
endmodule
